// File: src/bsfr_pkg.sv
// Shared types and codes for the byte-stuffed frame receiver.
// No dependencies; imported by the top, front and back modules (bsfr_queue does not import it).
`timescale 1ns / 1ps
`default_nettype none

package bsfr_pkg;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_START_CODE  = 2'd0,
      CSR_END_CODE    = 2'd1,
      CSR_ESCAPE_CODE = 2'd2
   } csr_index_type;

   // byte classes decided by the front end
   typedef enum logic [1:0] {
      CLS_ESCAPE = 2'd0,
      CLS_START  = 2'd1,
      CLS_END    = 2'd2,
      CLS_DATA   = 2'd3
   } cls_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   localparam logic [7:0] ESC_FLIP        = 8'h20;
   localparam logic [7:0] START_CODE_INIT = 8'd123;
   localparam logic [7:0] END_CODE_INIT   = 8'd125;
   localparam logic [7:0] ESC_CODE_INIT   = 8'd92;

   typedef struct packed {
      cls_type    cls;
      logic [7:0] data;
   } token_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] good_frames;
   } result_type;

endpackage

`default_nettype wire

// File: src/byte_stuffed_frame_receiver.sv
// Top level of the byte-stuffed frame receiver: front, middle queue, back, result queue.
// Depends on bsfr_pkg, bsfr_front, bsfr_queue and bsfr_back.
//
//   channel   ports                                            direction
//   request   push, full, req_rx_byte                          in
//   response  pop, empty, rsp_out_kind, rsp_out_byte,          out
//             rsp_good_frames
//   csr       csr_wen, csr_index, csr_wdata                    in
//
// One word per cycle sustained while pop keeps the result queue from filling; the back end sets the rate.
// A word is registered in the middle queue and its result in the result queue,
// from whose head pop takes it.
// Reset is synchronous and clears the codes to defaults and all frame state.
// A stalled pop fills the result queue, then the middle queue, then raises full.
`timescale 1ns / 1ps
`default_nettype none

module byte_stuffed_frame_receiver
   import bsfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_rx_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_out_kind,
   output logic [7:0]       rsp_out_byte,
   output logic [15:0]      rsp_good_frames
);

   token_type  front_tok, back_tok;
   logic       tok_push, tok_full, tok_empty, tok_pop;
   result_type res, res_head;
   logic       res_push, res_full;

   bsfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push),
      .rx_byte   (req_rx_byte),
      .tok_full  (tok_full),
      .tok_push  (tok_push),
      .tok       (front_tok)
   );

   bsfr_queue #(.WIDTH($bits(token_type))) u_tok_queue (
      .clock (clock),
      .reset (reset),
      .push  (tok_push),
      .din   (front_tok),
      .full  (tok_full),
      .pop   (tok_pop),
      .dout  (back_tok),
      .empty (tok_empty)
   );

   bsfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (!tok_empty),
      .tok       (back_tok),
      .tok_pop   (tok_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res)
   );

   bsfr_queue #(.WIDTH($bits(result_type))) u_res_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res),
      .full  (res_full),
      .pop   (pop),
      .dout  (res_head),
      .empty (empty)
   );

   assign full            = tok_full;
   assign rsp_out_kind    = res_head.kind;
   assign rsp_out_byte    = res_head.data;
   assign rsp_good_frames = res_head.good_frames;

endmodule

`default_nettype wire

// File: src/bsfr_queue.sv
// Two-entry word queue with push/full and pop/empty sides.
// Generic; used between front and back and on the result side.
`timescale 1ns / 1ps
`default_nettype none

module bsfr_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      dout,
   output logic                  empty
);

   logic [1:0]       cnt_ff, cnt_in;
   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] spare_ff, spare_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign dout    = head_ff;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      cnt_in   = cnt_ff;
      head_in  = head_ff;
      spare_in = spare_ff;
      case (cnt_ff)
         2'd0: begin
            if (do_push) begin
               head_in = din;
               cnt_in  = 2'd1;
            end
         end
         2'd1: begin
            if (do_push && do_pop) begin
               head_in = din;
            end else if (do_push) begin
               spare_in = din;
               cnt_in   = 2'd2;
            end else if (do_pop) begin
               cnt_in = 2'd0;
            end
         end
         2'd2: begin
            // full: advance the spare word into the head
            if (do_pop) begin
               head_in = spare_ff;
               cnt_in  = 2'd1;
            end
         end
         default: begin
            cnt_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

endmodule

`default_nettype wire

// File: src/bsfr_front.sv
// Front end: code registers and byte classification.
// Depends on bsfr_pkg; feeds the middle bsfr_queue.
`timescale 1ns / 1ps
`default_nettype none

module bsfr_front
   import bsfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wen,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata,
   input  wire logic       push,
   input  wire logic [7:0] rx_byte,
   input  wire logic       tok_full,
   output logic            tok_push,
   output token_type       tok
);

   logic [7:0] start_code_ff;
   logic [7:0] end_code_ff;
   logic [7:0] esc_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff <= START_CODE_INIT;
         end_code_ff   <= END_CODE_INIT;
         esc_code_ff   <= ESC_CODE_INIT;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_START_CODE:  start_code_ff <= csr_wdata;
            CSR_END_CODE:    end_code_ff   <= csr_wdata;
            CSR_ESCAPE_CODE: esc_code_ff   <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // escape wins over start, start over end
   always_comb begin
      tok.data = rx_byte;
      if (rx_byte == esc_code_ff) begin
         tok.cls = CLS_ESCAPE;
      end else if (rx_byte == start_code_ff) begin
         tok.cls = CLS_START;
      end else if (rx_byte == end_code_ff) begin
         tok.cls = CLS_END;
      end else begin
         tok.cls = CLS_DATA;
      end
   end

   assign tok_push = push && !tok_full;

endmodule

`default_nettype wire

// File: src/bsfr_back.sv
// Back end: frame state, unescape, checksum, one-word payload delay, verdict.
// Depends on bsfr_pkg; drains the middle queue into the result queue.
`timescale 1ns / 1ps
`default_nettype none

module bsfr_back
   import bsfr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      tok_valid,
   input  wire token_type tok,
   output logic           tok_pop,
   input  wire logic      res_full,
   output logic           res_push,
   output result_type     res
);

   logic        in_frame_ff, in_frame_in;
   logic        esc_ff, esc_in;
   logic [7:0]  sum_ff, sum_in;
   logic        held_valid_ff, held_valid_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  plain;
   logic        good;

   assign tok_pop = tok_valid && !res_full;
   assign plain   = esc_ff ? (tok.data ^ ESC_FLIP) : tok.data;
   assign good    = (sum_ff == 8'd0);

   always_comb begin
      in_frame_in   = in_frame_ff;
      esc_in        = esc_ff;
      sum_in        = sum_ff;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      count_in      = count_ff;
      res_push      = 1'b0;
      res.kind      = KIND_PAYLOAD;
      res.data      = 8'd0;
      if (tok_pop) begin
         case (tok.cls)
            CLS_ESCAPE: begin
               esc_in = 1'b1;
            end
            CLS_START: begin
               // drop any open frame and restart
               in_frame_in   = 1'b1;
               esc_in        = 1'b0;
               sum_in        = 8'd0;
               held_valid_in = 1'b0;
            end
            CLS_END: begin
               if (in_frame_ff) begin
                  in_frame_in   = 1'b0;
                  held_valid_in = 1'b0;
                  res_push      = 1'b1;
                  if (good) begin
                     count_in = count_ff + 16'd1;
                     res.kind = KIND_ACCEPT;
                  end else begin
                     res.kind = KIND_REJECT;
                  end
               end
            end
            default: begin
               if (in_frame_ff) begin
                  esc_in        = 1'b0;
                  sum_in        = sum_ff + plain;
                  held_valid_in = 1'b1;
                  held_byte_in  = plain;
                  if (held_valid_ff) begin
                     res_push = 1'b1;
                     res.data = held_byte_ff;
                  end
               end
            end
         endcase
      end
      res.good_frames = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         esc_ff        <= 1'b0;
         sum_ff        <= 8'd0;
         held_valid_ff <= 1'b0;
         count_ff      <= 16'd0;
      end else begin
         in_frame_ff   <= in_frame_in;
         esc_ff        <= esc_in;
         sum_ff        <= sum_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
      end
      held_byte_ff <= held_byte_in;
   end

`ifndef SYNTHESIS
   a_accept_counts: assert property (@(posedge clock) disable iff (reset)
      res_push && res.kind == KIND_ACCEPT |=> count_ff == $past(count_ff) + 16'd1)
      else $error("accept verdict without count advance");

   a_payload_in_frame: assert property (@(posedge clock) disable iff (reset)
      res_push && res.kind == KIND_PAYLOAD |-> in_frame_ff && held_valid_ff)
      else $error("payload word emitted outside a frame");

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      tok_pop && tok.cls == CLS_END |=> !in_frame_ff && !held_valid_ff)
      else $error("frame still open after end code");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      res_full |-> !res_push)
      else $error("result pushed into a full queue");
`endif

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking bench for byte_stuffed_frame_receiver: frame scoreboard class plus queue drivers.
// Depends on bsfr_pkg for result kinds, register indexes and reset codes.
`timescale 1ns / 1ps

module testbench;
   import bsfr_pkg::*;

   localparam int DRAIN_CYCLES = 20;

   // Tracks deframer state and the results it should emit.
   class frame_scoreboard;
      logic [7:0]  start_code;
      logic [7:0]  end_code;
      logic [7:0]  escape_code;
      bit          in_frame;
      bit          escape_pending;
      bit          held_valid;
      logic [7:0]  running_sum;
      logic [7:0]  held_byte;
      logic [15:0] good_count;
      result_type  expected_q[$];
      int          errors;

      function new();
         start_code     = START_CODE_INIT;
         end_code       = END_CODE_INIT;
         escape_code    = ESC_CODE_INIT;
         in_frame       = 1'b0;
         escape_pending = 1'b0;
         held_valid     = 1'b0;
         running_sum    = 8'd0;
         held_byte      = 8'd0;
         good_count     = 16'd0;
         errors         = 0;
      endfunction

      function void set_code(csr_index_type idx, logic [7:0] value);
         case (idx)
            CSR_START_CODE:  start_code  = value;
            CSR_END_CODE:    end_code    = value;
            CSR_ESCAPE_CODE: escape_code = value;
            default: ;
         endcase
      endfunction

      function void add_result(kind_type kind, logic [7:0] data);
         result_type r;
         r.kind        = kind;
         r.data        = data;
         r.good_frames = good_count;
         expected_q.push_back(r);
      endfunction

      // escape wins over start, start over end
      function void note_byte(logic [7:0] b);
         logic [7:0] d;
         d = b;
         if (b == escape_code) begin
            escape_pending = 1'b1;
         end else if (b == start_code) begin
            in_frame       = 1'b1;
            escape_pending = 1'b0;
            running_sum    = 8'd0;
            held_valid     = 1'b0;
            held_byte      = 8'd0;
         end else if (b == end_code) begin
            if (in_frame) begin
               if (running_sum == 8'd0) begin
                  good_count = good_count + 16'd1;
                  add_result(KIND_ACCEPT, 8'd0);
               end else begin
                  add_result(KIND_REJECT, 8'd0);
               end
               in_frame   = 1'b0;
               held_valid = 1'b0;
               held_byte  = 8'd0;
            end
         end else if (in_frame) begin
            if (escape_pending) begin
               d = b ^ ESC_FLIP;
            end
            escape_pending = 1'b0;
            running_sum    = running_sum + d;
            // hold one word back so the trailing checksum never leaves
            if (held_valid) begin
               add_result(KIND_PAYLOAD, held_byte);
            end
            held_byte  = d;
            held_valid = 1'b1;
         end
      endfunction

      function void check_result(logic [1:0] kind, logic [7:0] data, logic [15:0] frames);
         result_type r;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected word kind=%0d byte=%02h frames=%0d",
                     $time, kind, data, frames);
         end else begin
            r = expected_q.pop_front();
            if (r.kind != kind) begin
               errors++;
               $display("%0t: out_kind expected %0d actual %0d", $time, r.kind, kind);
            end
            if (r.data != data) begin
               errors++;
               $display("%0t: out_byte expected %02h actual %02h", $time, r.data, data);
            end
            if (r.good_frames != frames) begin
               errors++;
               $display("%0t: good_frames expected %0d actual %0d",
                        $time, r.good_frames, frames);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wen;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;
   logic        push;
   logic        full;
   logic [7:0]  req_rx_byte;
   logic        empty;
   logic        pop;
   logic [1:0]  rsp_out_kind;
   logic [7:0]  rsp_out_byte;
   logic [15:0] rsp_good_frames;

   frame_scoreboard sb = new();
   bit quiet;
   int sent_count;

   byte_stuffed_frame_receiver uut (
      .clock           (clock),
      .reset           (reset),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .push            (push),
      .full            (full),
      .req_rx_byte     (req_rx_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_good_frames (rsp_good_frames)
   );

   always #5 clock = ~clock;

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      push        <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (full);
      sb.note_byte(b);
      sent_count++;
   endtask

   // escape any value that collides with a code, and some others at random
   task automatic send_value(input logic [7:0] v);
      if (v == sb.start_code || v == sb.end_code || v == sb.escape_code ||
          $urandom_range(0, 15) == 0) begin
         send_byte(sb.escape_code);
         send_byte(v ^ ESC_FLIP);
      end else begin
         send_byte(v);
      end
   endtask

   task automatic send_frame(input bit closed);
      int         n;
      logic [7:0] v;
      logic [7:0] total;
      n     = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      total = 8'd0;
      send_byte(sb.start_code);
      repeat (n) begin
         v     = 8'($urandom);
         total = total + v;
         send_value(v);
      end
      if (n != 0) begin
         v = 8'd0 - total;
         if ($urandom_range(0, 3) == 0) begin
            v = v + 8'($urandom_range(1, 255));
         end
         send_value(v);
      end
      if (closed) begin
         send_byte(sb.end_code);
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 5))
            0:       send_byte(sb.start_code);
            1:       send_byte(sb.end_code);
            2:       send_byte(sb.escape_code);
            default: send_byte(8'($urandom));
         endcase
      end
   endtask

   task automatic run_random(input int count);
      int stop_at;
      int pick;
      stop_at = sent_count + count;
      while (sent_count < stop_at) begin
         if (sent_count > 1100) begin
            quiet = 1'b1;
         end
         pick = $urandom_range(0, 9);
         if (pick <= 6) begin
            send_frame(1'b1);
         end else if (pick <= 8) begin
            send_noise();
         end else begin
            send_frame(1'b0);
         end
      end
   endtask

   // drop push and let every word drain, including ones that make no result
   task automatic drain();
      @(negedge clock);
      push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_code(input csr_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      sb.set_code(idx, value);
   endtask

   task automatic load_codes(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x);
      write_code(CSR_START_CODE, s);
      write_code(CSR_END_CODE, e);
      write_code(CSR_ESCAPE_CODE, x);
   endtask

   // result side: random pop stalls, none once quiet
   initial begin : result_side
      int   hold;
      logic want;
      hold = 0;
      pop  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            want = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 3) - 1;
            want = 1'b0;
         end else begin
            want = 1'b1;
         end
         pop <= want;
         @(posedge clock);
         if (!reset && pop && !empty) begin
            sb.check_result(rsp_out_kind, rsp_out_byte, rsp_good_frames);
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [7:0] directed_q[$];
      logic [7:0] s;
      logic [7:0] e;
      logic [7:0] x;
      clock       = 1'b0;
      reset       = 1'b1;
      csr_wen     = 1'b0;
      csr_index   = CSR_START_CODE;
      csr_wdata   = 8'd0;
      push        = 1'b0;
      req_rx_byte = 8'd0;
      quiet       = 1'b0;
      sent_count  = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stray data, stray end, escape outside a frame, empty frame
      directed_q = {8'h00, END_CODE_INIT, ESC_CODE_INIT, START_CODE_INIT, END_CODE_INIT};
      // escaped start value inside a good frame
      directed_q = {directed_q, START_CODE_INIT, 8'hFF, ESC_CODE_INIT,
                    START_CODE_INIT ^ ESC_FLIP, 8'h86, END_CODE_INIT};
      // restart inside a frame, then escape followed by end acts on the end
      directed_q = {directed_q, START_CODE_INIT, 8'h01, START_CODE_INIT, 8'h10,
                    ESC_CODE_INIT, END_CODE_INIT};
      // bad checksum, then escape before start
      directed_q = {directed_q, START_CODE_INIT, 8'h80, 8'h55, 8'hAA, END_CODE_INIT,
                    ESC_CODE_INIT, START_CODE_INIT, END_CODE_INIT};
      foreach (directed_q[i]) begin
         send_byte(directed_q[i]);
      end
      run_random(100);

      drain();
      load_codes(8'h00, 8'hFF, 8'h80);
      run_random(280);

      drain();
      load_codes(8'hFF, 8'h00, 8'h01);
      run_random(280);

      // start and end coincide, escape sits 0x20 away from them
      drain();
      load_codes(8'h10, 8'h10, 8'h30);
      run_random(100);

      drain();
      s = 8'($urandom);
      do e = 8'($urandom); while (e == s);
      do x = 8'($urandom); while (x == s || x == e);
      load_codes(s, e, x);
      run_random(250);

      drain();
      load_codes(START_CODE_INIT, END_CODE_INIT, ESC_CODE_INIT);
      run_random(220);

      drain();
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
